### sv/cbd_pkg.sv
`timescale 1ns / 1ps
package cbd_pkg;

  localparam int unsigned BlockW = 64;
  localparam int unsigned HalfW  = BlockW / 2;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] MixMulA = 8'd63;
  localparam logic [7:0] MixMulC = 8'd17;
  localparam logic [7:0] MixAddG = 8'd51;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KEY_FIRST  = 2'd0,
    CFG_KEY_SECOND = 2'd1,
    CFG_KEY_THIRD  = 2'd2,
    CFG_FULL_MODE  = 2'd3
  } cfg_idx_e;

  // block in flight plus the raw input of the block before it
  typedef struct packed {
    logic [BlockW-1:0] word;
    logic [BlockW-1:0] prev;
  } cbd_item_t;

  // first half of the byte mix
  typedef struct packed {
    cbd_item_t  item;
    logic [7:0] b;
    logic [7:0] d;
    logic [7:0] e;
  } cbd_part_t;

endpackage

### sv/cbd_mix_front.sv
`timescale 1ns / 1ps
module cbd_mix_front
  import cbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  cbd_item_t item_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cbd_part_t part_o
);

  logic      valid_q;
  cbd_part_t part_q, part_d;
  logic [7:0] b0, b1, b2, b3, a, c;

  assign b0 = item_i.word[7:0];
  assign b1 = item_i.word[15:8];
  assign b2 = item_i.word[23:16];
  assign b3 = item_i.word[31:24];

  always_comb begin
    a = 8'(b0 * MixMulA);
    c = 8'(b1 * MixMulC);
    part_d.item = item_i;
    part_d.b    = a + b3;
    part_d.d    = c + b2;
    part_d.e    = part_d.d + part_d.b;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      part_q <= part_d;
    end
  end

  assign valid_o = valid_q;
  assign part_o  = part_q;

endmodule

### sv/cbd_mix_back.sv
`timescale 1ns / 1ps
module cbd_mix_back
  import cbd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      mix_en_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  cbd_part_t part_i,
  output logic      valid_o,
  input  logic      ready_i,
  output cbd_item_t item_o
);

  logic      valid_q;
  cbd_item_t item_q, item_d;
  logic [7:0] b3, f, g, h, i;

  assign b3 = part_i.item.word[31:24];

  always_comb begin
    f = 8'(part_i.e * b3);
    g = f + part_i.b + MixAddG;
    h = part_i.b ^ part_i.d;
    i = g ^ part_i.e;
    item_d = part_i.item;
    if (mix_en_i) begin
      item_d.word[BlockW-1:HalfW] = part_i.item.word[BlockW-1:HalfW] ^ {g, i, part_i.d, h};
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### sv/chained_block_descrambler_unit.sv
`timescale 1ns / 1ps
// Six register stages lie between input accept and output valid (input reg,
// two mix halves per round, output reg), independent of mode.
// Throughput: one item per cycle; each stage holds under backpressure.
// Reset: pipeline empty, keys zero, full mode on, chain value zero.
// Config writes are taken every cycle (cfg_ready_o tied high).
module chained_block_descrambler_unit
  import cbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [BlockW-1:0]  s_axis_tdata_i,   // [63:0] scrambled_block
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [BlockW-1:0]  m_axis_tdata_o,   // [63:0] plain_block
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BlockW-1:0]  cfg_data_i
);

  logic [BlockW-1:0] key0_q, key1_q, key2_q, chain_q;
  logic              full_q;

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key0_q <= '0;
      key1_q <= '0;
      key2_q <= '0;
      full_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_KEY_FIRST:  key0_q <= cfg_data_i;
        CFG_KEY_SECOND: key1_q <= cfg_data_i;
        CFG_KEY_THIRD:  key2_q <= cfg_data_i;
        CFG_FULL_MODE:  full_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 0: key word 0, capture chain value
  logic      s0_valid_q, s0_ready;
  cbd_item_t s0_item_q;

  logic      s1_valid, s1_ready;
  cbd_part_t s1_part;
  logic      s2_valid, s2_ready;
  cbd_item_t s2_item, s2_fwd;
  logic      s3_valid, s3_ready;
  cbd_part_t s3_part;
  logic      s4_valid, s4_ready;
  cbd_item_t s4_item;

  logic              out_valid_q;
  logic              out_ready;
  logic [BlockW-1:0] out_data_q, out_data_d;

  assign s0_ready        = !s0_valid_q || s1_ready;
  assign s_axis_tready_o = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      chain_q    <= '0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= s_axis_tvalid_i;
      end
      if (s0_ready && s_axis_tvalid_i) begin
        chain_q <= s_axis_tdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_ready && s_axis_tvalid_i) begin
      s0_item_q.word <= s_axis_tdata_i ^ key0_q;
      s0_item_q.prev <= chain_q;
    end
  end

  // round 1
  cbd_mix_front u_front1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s0_valid_q),
    .ready_o (s1_ready),
    .item_i  (s0_item_q),
    .valid_o (s1_valid),
    .ready_i (s2_ready),
    .part_o  (s1_part)
  );

  cbd_mix_back u_back1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mix_en_i (1'b1),
    .valid_i  (s1_valid),
    .ready_o  (s2_ready),
    .part_i   (s1_part),
    .valid_o  (s2_valid),
    .ready_i  (s3_ready),
    .item_o   (s2_item)
  );

  // half swap, then key word 1 in full mode
  always_comb begin
    s2_fwd      = s2_item;
    s2_fwd.word = {s2_item.word[HalfW-1:0], s2_item.word[BlockW-1:HalfW]};
    if (full_q) begin
      s2_fwd.word = s2_fwd.word ^ key1_q;
    end
  end

  // round 2, mix bypassed in single-round mode
  cbd_mix_front u_front2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s3_ready),
    .item_i  (s2_fwd),
    .valid_o (s3_valid),
    .ready_i (s4_ready),
    .part_o  (s3_part)
  );

  cbd_mix_back u_back2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mix_en_i (full_q),
    .valid_i  (s3_valid),
    .ready_o  (s4_ready),
    .part_i   (s3_part),
    .valid_o  (s4_valid),
    .ready_i  (out_ready),
    .item_o   (s4_item)
  );

  // output stage: chain, and key word 2 in full mode
  assign out_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_data_d = s4_item.word ^ s4_item.prev;
    if (full_q) begin
      out_data_d = out_data_d ^ key2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s4_valid) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

### tb/cbd_block_checker.sv
`timescale 1ns / 1ps
module cbd_block_checker
  import cbd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  input  logic               s_axis_tready_i,
  input  logic [BlockW-1:0]  s_axis_tdata_i,
  input  logic               m_axis_tvalid_i,
  input  logic               m_axis_tready_i,
  input  logic [BlockW-1:0]  m_axis_tdata_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BlockW-1:0]  cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  logic [BlockW-1:0] key_first_q;
  logic [BlockW-1:0] key_second_q;
  logic [BlockW-1:0] key_third_q;
  logic              full_mode_q;
  logic [BlockW-1:0] prev_raw_q;
  logic [BlockW-1:0] plain_exp_q[$];
  int                fail_cnt;

  // bytes 4..7 pick up values derived from bytes 0..3, all mod 256
  function automatic logic [BlockW-1:0] mix_bytes(input logic [BlockW-1:0] w);
    logic [7:0] a, b, c, d, e, f, g, h, x;
    a = w[7:0] * 8'd63;
    b = a + w[31:24];
    c = w[15:8] * 8'd17;
    d = c + w[23:16];
    e = d + b;
    f = e * w[31:24];
    g = f + b + 8'd51;
    h = b ^ d;
    x = g ^ e;
    return w ^ {g, x, d, h, 32'h0};
  endfunction

  function automatic logic [BlockW-1:0] descramble_block(input logic [BlockW-1:0] raw);
    logic [BlockW-1:0] w;
    w = mix_bytes(raw ^ key_first_q);
    w = {w[HalfW-1:0], w[BlockW-1:HalfW]};
    if (full_mode_q) begin
      w = mix_bytes(w ^ key_second_q) ^ key_third_q;
    end
    return w ^ prev_raw_q;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [BlockW-1:0] exp_blk;
    if (!rst_ni) begin
      key_first_q  = '0;
      key_second_q = '0;
      key_third_q  = '0;
      full_mode_q  = 1'b1;
      prev_raw_q   = '0;
      plain_exp_q.delete();
      fail_cnt     = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_KEY_FIRST:  key_first_q  = cfg_data_i;
          CFG_KEY_SECOND: key_second_q = cfg_data_i;
          CFG_KEY_THIRD:  key_third_q  = cfg_data_i;
          CFG_FULL_MODE:  full_mode_q  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        plain_exp_q.push_back(descramble_block(s_axis_tdata_i));
        prev_raw_q = s_axis_tdata_i;
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (plain_exp_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("%0t: unexpected result item %h", $time, m_axis_tdata_i);
          end
        end else begin
          exp_blk = plain_exp_q.pop_front();
          if (m_axis_tdata_i !== exp_blk) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("%0t: plain_block mismatch: expected %h, got %h",
                       $time, exp_blk, m_axis_tdata_i);
            end
          end
        end
      end
    end
    fail_count_o <= fail_cnt;
    pending_o    <= plain_exp_q.size();
  end

endmodule

### tb/tb_chained_block_descrambler_unit.sv
`timescale 1ns / 1ps
module tb_chained_block_descrambler_unit;
  import cbd_pkg::*;

  localparam int IdleLimit = 2000;
  localparam int PhaseItems = 250;
  localparam int NumPhases = 8;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [BlockW-1:0]  s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [BlockW-1:0]  m_axis_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [BlockW-1:0]  cfg_data;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  int                 send_burst;
  int                 recv_burst;

  chained_block_descrambler_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  cbd_block_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // wait before the next item; occasional bursts with no gaps at all
  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // mostly random words, with bytes pinned to 00 or FF now and then
  function automatic logic [BlockW-1:0] rand_word();
    logic [BlockW-1:0] w;
    w = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: w = '0;
      1: w = '1;
      2, 3: begin
        for (int k = 0; k < BlockW / 8; k++) begin
          case ($urandom_range(0, 2))
            0: w[8*k +: 8] = 8'h00;
            1: w[8*k +: 8] = 8'hFF;
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_block(input logic [BlockW-1:0] blk);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= blk;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // stop sending and let every expected item come out, plus pipeline margin
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [BlockW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    recv_burst = 0;
    wait (rst_ni === 1'b1);
    forever begin
      int stall;
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("FAIL chained_block_descrambler_unit");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= CFG_KEY_FIRST;
    cfg_data      <= '0;
    send_burst = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: zero keys, two rounds, chain starts at zero
    send_block('0);
    send_block('1);
    send_block(64'h0123_4567_89AB_CDEF);
    send_block(64'hFF00_FF00_FF00_FF00);
    send_block(64'h0000_0000_FFFF_FFFF);
    send_block(64'hFFFF_FFFF_0000_0000);
    drain_pipeline();

    // all-ones keys; full mode written with a wide value that keeps bit 0 set
    write_reg(CFG_KEY_FIRST, '1);
    write_reg(CFG_KEY_SECOND, '1);
    write_reg(CFG_KEY_THIRD, '1);
    write_reg(CFG_FULL_MODE, '1);
    send_block('0);
    send_block('1);
    send_block(64'h8080_8080_8080_8080);
    send_block(64'h7F7F_7F7F_7F7F_7F7F);
    send_block(64'h0000_0000_0000_0001);
    send_block(64'h8000_0000_0000_0000);
    drain_pipeline();

    // single round; wide value with bit 0 clear
    write_reg(CFG_FULL_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CFG_KEY_FIRST, '0);
    send_block('1);
    send_block('0);
    send_block(64'hA5A5_A5A5_5A5A_5A5A);
    send_block(64'h00FF_00FF_00FF_00FF);
    send_block(64'hFFFF_FFFF_0000_0000);
    send_block(64'h0000_0001_0000_0000);
    drain_pipeline();

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_reg(CFG_KEY_FIRST, rand_word());
      write_reg(CFG_KEY_SECOND, rand_word());
      write_reg(CFG_KEY_THIRD, rand_word());
      write_reg(CFG_FULL_MODE, {$urandom(), $urandom()});
      for (int n = 0; n < PhaseItems; n++) begin
        send_block(rand_word());
        if (ph == 3 && n == PhaseItems / 2) begin
          drain_pipeline();
        end
      end
      drain_pipeline();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS chained_block_descrambler_unit");
    end else begin
      $display("FAIL chained_block_descrambler_unit");
    end
    $finish;
  end

endmodule
